// ===== design/srrt_pkg.sv =====
// Shared types and codes for the sorted range record table.
package srrt_pkg;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] region_size;
    logic [31:0] region_attr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_base;
    logic [31:0] hit_size;
    logic [31:0] hit_attr;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
    logic [31:0] flags;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       pos_clr;
    logic       pos_ld_cnt;
    logic       pos_inc;
    logic       pos_dec;
    logic       rd_prev;
    logic       wr_en;
    logic       wr_prev;
    logic       wr_sel_new;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       finish;
    logic [1:0] fin_status;
    logic       fin_hit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       full;
    logic       pos_zero;
    logic       pos_end;
    logic       base_eq;
    logic       base_gt;
    logic       in_range;
  } sts_t;

endpackage

// ===== design/srrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module srrt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/srrt_ctrl.sv =====
// Controller state machine that sequences add, free and find commands.
module srrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_command,
  input  srrt_pkg::sts_t sts,
  output logic           busy,
  output srrt_pkg::ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ADD_RD   = 8'b0000_0010,
    S_ADD_CHK  = 8'b0000_0100,
    S_SRCH_RD  = 8'b0000_1000,
    S_SRCH_CHK = 8'b0001_0000,
    S_SHIFT_RD = 8'b0010_0000,
    S_SHIFT_WR = 8'b0100_0000,
    S_UNUSED   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (in_command == srrt_pkg::CMD_ADD && sts.full) begin
            ctl.finish     = 1'b1;
            ctl.fin_status = srrt_pkg::ST_FULL;
          end else if (in_command == srrt_pkg::CMD_ADD) begin
            ctl.load       = 1'b1;
            ctl.pos_ld_cnt = 1'b1;
            state_nxt      = S_ADD_RD;
          end else if (in_command == srrt_pkg::CMD_FREE ||
                       in_command == srrt_pkg::CMD_FIND) begin
            ctl.load    = 1'b1;
            ctl.pos_clr = 1'b1;
            state_nxt   = S_SRCH_RD;
          end else begin
            ctl.finish     = 1'b1;
            ctl.fin_status = srrt_pkg::ST_MISS;
          end
        end
      end
      S_ADD_RD: begin
        // Walking down from the top; slot zero means every entry moved up.
        if (sts.pos_zero) begin
          ctl.wr_en      = 1'b1;
          ctl.wr_sel_new = 1'b1;
          ctl.cnt_inc    = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          ctl.rd_prev = 1'b1;
          state_nxt   = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        ctl.wr_en = 1'b1;
        if (sts.base_gt) begin
          ctl.pos_dec = 1'b1;
          state_nxt   = S_ADD_RD;
        end else begin
          ctl.wr_sel_new = 1'b1;
          ctl.cnt_inc    = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_SRCH_RD: begin
        if (sts.pos_end) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        priority if (sts.req_cmd == srrt_pkg::CMD_FREE) begin
          ctl.pos_inc = 1'b1;
          state_nxt   = sts.base_eq ? S_SHIFT_RD : S_SRCH_RD;
        end else if (sts.in_range) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_OK;
          ctl.fin_hit    = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.base_gt) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          ctl.pos_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.pos_end) begin
          ctl.cnt_dec    = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = srrt_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_prev = 1'b1;
        ctl.pos_inc = 1'b1;
        state_nxt   = S_SHIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/srrt_dp.sv =====
// Datapath: request register, position and count registers, entry RAM and compares.
module srrt_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srrt_pkg::in_item_t  in_item,
  input  srrt_pkg::ctl_t      ctl,
  output srrt_pkg::sts_t      sts,
  output logic                out_valid,
  output srrt_pkg::out_item_t out_item
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  srrt_pkg::in_item_t  req_r;
  srrt_pkg::out_item_t out_item_r;
  srrt_pkg::entry_t    rd_entry, wr_entry, new_entry;
  logic [CW-1:0]       pos_r, cnt_r, pos_m1;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                out_valid_r;
  logic [32:0]         end_sum;

  assign pos_m1  = pos_r - CW'(1);
  assign rd_addr = ctl.rd_prev ? pos_m1[AW-1:0] : pos_r[AW-1:0];
  assign wr_addr = ctl.wr_prev ? pos_m1[AW-1:0] : pos_r[AW-1:0];

  assign new_entry.base   = req_r.address;
  assign new_entry.length = req_r.region_size;
  assign new_entry.flags  = req_r.region_attr;
  assign wr_entry         = ctl.wr_sel_new ? new_entry : rd_entry;

  srrt_ram #(
    .WIDTH($bits(srrt_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Region end is formed one bit wider so it never wraps.
  assign end_sum = {1'b0, rd_entry.base} + {1'b0, rd_entry.length};

  assign sts.req_cmd  = req_r.command;
  assign sts.full     = (cnt_r == CW'(TABLE_DEPTH));
  assign sts.pos_zero = (pos_r == '0);
  assign sts.pos_end  = (pos_r == cnt_r);
  assign sts.base_eq  = (rd_entry.base == req_r.address);
  assign sts.base_gt  = (rd_entry.base > req_r.address);
  assign sts.in_range = (rd_entry.base <= req_r.address) &&
                        (end_sum > {1'b0, req_r.address});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_item;
    end
    if (ctl.finish) begin
      out_item_r.status <= ctl.fin_status;
      if (ctl.fin_hit) begin
        out_item_r.hit_base <= rd_entry.base;
        out_item_r.hit_size <= rd_entry.length;
        out_item_r.hit_attr <= rd_entry.flags;
      end else begin
        out_item_r.hit_base <= '0;
        out_item_r.hit_size <= '0;
        out_item_r.hit_attr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.pos_clr) begin
        pos_r <= '0;
      end else if (ctl.pos_ld_cnt) begin
        pos_r <= cnt_r;
      end else if (ctl.pos_inc) begin
        pos_r <= pos_r + CW'(1);
      end else if (ctl.pos_dec) begin
        pos_r <= pos_m1;
      end
      if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (ctl.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/sorted_range_record_table.sv =====
// Top level of the sorted range record table: controller plus datapath.
// The table holds up to TABLE_DEPTH regions sorted by base in one RAM with a
// registered read, so every entry visited takes an address state and then a
// compare state. A command is taken when start is high and busy is low; its
// single result is shown on out_item for exactly one cycle with out_valid
// high, and the receiver cannot stall it. An add on a full table and the
// unused command code finish with a result in the cycle after the transfer
// and never raise busy. An add walks down from the top, moving each entry
// with a higher base up one slot, and writes the new region into the slot
// left free. A find compares entries in base order until a hit, a higher
// base or the last entry. A free visits every entry whether it hits or
// misses: it scans to the match, then moves each later entry down one slot.
// The result shows in the first cycle with busy low. The RAM starts undefined
// and needs no clearing pass.
module sorted_range_record_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output srrt_pkg::out_item_t out_item
);

  srrt_pkg::ctl_t ctl;
  srrt_pkg::sts_t sts;

  srrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_item.command),
    .sts        (sts),
    .busy       (busy),
    .ctl        (ctl)
  );

  srrt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== tb/range_table_checker.sv =====
// Checker for the sorted range record table: tracks the region table and compares every result.
`timescale 1ns / 100ps

module range_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  srrt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  srrt_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_results
);

  srrt_pkg::entry_t    stored_regions [TABLE_DEPTH];
  int unsigned         region_count;
  srrt_pkg::out_item_t expected_results [$];
  srrt_pkg::out_item_t oldest;

  // Applies one command to the tracked table and returns the result it must produce.
  function automatic srrt_pkg::out_item_t apply_table_command(srrt_pkg::in_item_t cmd_item);
    srrt_pkg::out_item_t res;
    int unsigned         pos;
    int unsigned         k;
    logic [32:0]         region_end;
    res        = '0;
    res.status = srrt_pkg::ST_MISS;
    pos        = 0;
    case (cmd_item.command)
      srrt_pkg::CMD_ADD: begin
        if (region_count >= TABLE_DEPTH) begin
          res.status = srrt_pkg::ST_FULL;
        end else begin
          // Equal bases keep their order: the new region goes after them.
          while (pos < region_count && stored_regions[pos].base <= cmd_item.address)
            pos++;
          for (k = region_count; k > pos; k--)
            stored_regions[k] = stored_regions[k - 1];
          stored_regions[pos].base   = cmd_item.address;
          stored_regions[pos].length = cmd_item.region_size;
          stored_regions[pos].flags  = cmd_item.region_attr;
          region_count++;
          res.status = srrt_pkg::ST_OK;
        end
      end
      srrt_pkg::CMD_FREE: begin
        while (pos < region_count && stored_regions[pos].base != cmd_item.address)
          pos++;
        if (pos < region_count) begin
          for (k = pos; k + 1 < region_count; k++)
            stored_regions[k] = stored_regions[k + 1];
          region_count--;
          res.status = srrt_pkg::ST_OK;
        end
      end
      srrt_pkg::CMD_FIND: begin
        for (k = 0; k < region_count; k++) begin
          // The end of a region is formed one bit wider so that it never wraps.
          region_end = {1'b0, stored_regions[k].base} + {1'b0, stored_regions[k].length};
          if (stored_regions[k].base <= cmd_item.address &&
              region_end > {1'b0, cmd_item.address}) begin
            res.status   = srrt_pkg::ST_OK;
            res.hit_base = stored_regions[k].base;
            res.hit_size = stored_regions[k].length;
            res.hit_attr = stored_regions[k].flags;
            break;
          end
          if (stored_regions[k].base > cmd_item.address)
            break;
        end
      end
      default: begin
        res.status = srrt_pkg::ST_MISS;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count   = 0;
      region_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding: status 0x%0h", out_item.status);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", {30'b0, oldest.status}, {30'b0, out_item.status});
          check_field("hit_base", oldest.hit_base, out_item.hit_base);
          check_field("hit_size", oldest.hit_size, out_item.hit_size);
          check_field("hit_attr", oldest.hit_attr, out_item.hit_attr);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_table_command(in_item));
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== tb/sorted_range_record_table_tb.sv =====
// Testbench top for the sorted range record table: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module sorted_range_record_table_tb;

  localparam int         TABLE_DEPTH    = 64;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         PHASE_ITEMS    = 105;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  typedef struct {
    logic [31:0] base;
    logic [31:0] size;
  } region_ref_t;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  srrt_pkg::in_item_t  cmd_port = '0;
  logic                out_valid;
  srrt_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending_results;
  int                  quiet_cycles = 0;

  // Regions handed out so far, so that frees and finds often land on real entries.
  region_ref_t known_regions [$];

  sorted_range_record_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_port),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  range_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (cmd_port),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ends the run when neither a command nor a result transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic srrt_pkg::in_item_t make_command(logic [1:0] cmd, logic [31:0] addr,
                                                      logic [31:0] size, logic [31:0] attr);
    srrt_pkg::in_item_t it;
    it.command     = cmd;
    it.address     = addr;
    it.region_size = size;
    it.region_attr = attr;
    return it;
  endfunction

  function automatic srrt_pkg::in_item_t random_command(int add_pct);
    srrt_pkg::in_item_t it;
    int                 roll;
    int                 idx;
    it.region_attr = $urandom();
    case ($urandom_range(9))
      0:       it.region_size = '0;
      1:       it.region_size = $urandom();
      default: it.region_size = $urandom_range(32'h2000, 1);
    endcase
    case ($urandom_range(3))
      0, 1:    it.address = $urandom_range(32'hFFFF);
      2:       it.address = $urandom();
      default: it.address = {16'hFFFF, 16'($urandom())};
    endcase
    roll = $urandom_range(99);
    if (roll < add_pct) begin
      it.command = srrt_pkg::CMD_ADD;
      known_regions.push_back('{it.address, it.region_size});
      if (known_regions.size() > 200)
        void'(known_regions.pop_front());
    end else begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        it.command = CMD_UNUSED;
      end else if (roll < 55) begin
        it.command = srrt_pkg::CMD_FREE;
        if (known_regions.size() != 0 && $urandom_range(3) != 0) begin
          idx        = $urandom_range(known_regions.size() - 1);
          it.address = known_regions[idx].base;
          known_regions.delete(idx);
        end
      end else begin
        it.command = srrt_pkg::CMD_FIND;
        if (known_regions.size() != 0 && $urandom_range(9) < 7) begin
          idx        = $urandom_range(known_regions.size() - 1);
          it.address = known_regions[idx].base + $urandom_range(known_regions[idx].size);
        end
      end
    end
    return it;
  endfunction

  // Holds start high until the command transfer, then idles the sender at random.
  task automatic send_command(input srrt_pkg::in_item_t item, input int idle_pct);
    start    <= 1'b1;
    cmd_port <= item;
    do @(posedge clk); while (busy);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  initial begin
    srrt_pkg::in_item_t directed [$];
    int                 idle_by_phase [6];
    directed = '{
      make_command(srrt_pkg::CMD_FIND, 32'h0, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      make_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      make_command(srrt_pkg::CMD_ADD, 32'h1000, 32'h100, 32'hA5A5_A5A5),
      make_command(srrt_pkg::CMD_ADD, 32'h1000, 32'h200, 32'h5A5A_5A5A),
      make_command(srrt_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      make_command(srrt_pkg::CMD_ADD, 32'h800, 32'h1000, 32'h1),
      make_command(srrt_pkg::CMD_FIND, 32'h0, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'h1000, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'h17FF, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'h1800, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'hFFFF_FFFE, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h1000, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FIND, 32'h1100, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h1000, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h1000, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h0, 32'h0, 32'h0),
      make_command(srrt_pkg::CMD_FREE, 32'h800, 32'h0, 32'h0),
      make_command(CMD_UNUSED, 32'h0, 32'h0, 32'h0)
    };
    idle_by_phase = '{0, 62, 0, 31, 62, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_command(directed[i], 0);

    // Even phases fill the table past full; odd phases drain it with frees.
    for (int phase = 0; phase < 6; phase++) begin
      repeat (PHASE_ITEMS)
        send_command(random_command((phase % 2 == 0) ? 85 : 15), idle_by_phase[phase]);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
